// ----- sv/gsa_pkg.sv -----
// Shared types and constants of the generational slot allocator.
package gsa_pkg;

	localparam int HIDX_W = 10;
	localparam int GEN_W  = 32;
	localparam int CNT_W  = 11;
	localparam int EIDX_W = 32;

	typedef enum logic [1:0] {
		MODE_CREATE  = 2'd0,
		MODE_DESTROY = 2'd1,
		MODE_CHECK   = 2'd2,
		MODE_NOP     = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NONE_FREE = 2'd1,
		ST_INVALID   = 2'd2,
		ST_OVERFLOW  = 2'd3
	} status_t;

	typedef struct packed {
		logic capture;
		logic slot_rd;
		logic exec;
		logic clr;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic req_create;
		logic out_free;
	} stat_t;

endpackage

// ----- sv/gsa_ctrl.sv -----
// Sequencing state machine of the slot allocator.
module gsa_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  gsa_pkg::stat_t  stat,
	output gsa_pkg::cmd_t   cmd
);

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_SLOT,
		S_EXEC
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_CLEAR: cmd.clr = 1'b1;
			S_IDLE:  cmd.capture = in_valid;
			S_SLOT:  cmd.slot_rd = 1'b1;
			S_EXEC:  cmd.exec = stat.out_free;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					if (stat.clr_last) state_q <= S_IDLE;
				end
				S_IDLE: begin
					// A create first has to learn its slot from the free queue.
					if (in_valid) state_q <= stat.req_create ? S_SLOT : S_EXEC;
				end
				S_SLOT: state_q <= S_EXEC;
				S_EXEC: begin
					if (stat.out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- sv/gsa_dpath.sv -----
// Generation table, free queue, counters and result register of the allocator.
module gsa_dpath #(
	parameter int SLOT_COUNT = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  gsa_pkg::cmd_t                cmd,
	output gsa_pkg::stat_t               stat,
	input  logic [1:0]                   mode,
	input  logic [gsa_pkg::EIDX_W-1:0]   entity_index,
	input  logic [gsa_pkg::GEN_W-1:0]    entity_generation,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [gsa_pkg::HIDX_W-1:0]   handle_index,
	output logic [gsa_pkg::GEN_W-1:0]    handle_generation,
	output logic                         is_alive,
	output logic [1:0]                   status,
	output logic [gsa_pkg::CNT_W-1:0]    live_count
);

	localparam int IW = $clog2(SLOT_COUNT);
	localparam int CW = $clog2(SLOT_COUNT + 1);
	localparam logic [IW-1:0] LAST = IW'(SLOT_COUNT - 1);
	localparam logic [CW-1:0] FULL = CW'(SLOT_COUNT);

	logic [gsa_pkg::GEN_W-1:0] gen_mem [SLOT_COUNT];
	logic [IW-1:0]             queue_mem [SLOT_COUNT];

	logic [gsa_pkg::GEN_W-1:0]  gen_rd_q;
	logic [IW-1:0]              q_rd_q;
	logic [IW-1:0]              slot_q;
	gsa_pkg::mode_t             mode_q;
	logic [gsa_pkg::EIDX_W-1:0] idx_q;
	logic [gsa_pkg::GEN_W-1:0]  gen_in_q;

	logic [IW-1:0] head_q;
	logic [IW-1:0] tail_q;
	logic          wrap_q;
	logic [CW-1:0] fill_q;
	logic [CW-1:0] alloc_q;
	logic [IW-1:0] clr_q;

	logic                        out_valid_q;
	logic [gsa_pkg::HIDX_W-1:0]  hidx_q;
	logic [gsa_pkg::GEN_W-1:0]   hgen_q;
	logic                        alive_q;
	gsa_pkg::status_t            status_q;
	logic [gsa_pkg::CNT_W-1:0]   live_q;

	logic                        head_written;
	logic [IW-1:0]               pop_slot;
	logic                        idx_ok;
	logic                        q_empty;
	logic                        q_full;
	logic [gsa_pkg::GEN_W-1:0]   gen_inc;
	logic                        do_pop;
	logic                        do_push;
	logic [CW-1:0]               alloc_next;
	logic [gsa_pkg::HIDX_W-1:0]  r_index;
	logic [gsa_pkg::GEN_W-1:0]   r_gen;
	logic                        r_alive;
	gsa_pkg::status_t            r_status;

	logic                        gen_re;
	logic [IW-1:0]               gen_raddr;
	logic                        gen_we;
	logic [IW-1:0]               gen_waddr;
	logic [gsa_pkg::GEN_W-1:0]   gen_wdata;
	logic                        q_we;

	// Queue entries that were never pushed are not read; their own position stands in as the slot.
	assign head_written = wrap_q || (head_q < tail_q);
	assign pop_slot     = head_written ? q_rd_q : head_q;
	assign idx_ok       = (idx_q < gsa_pkg::EIDX_W'(SLOT_COUNT));
	assign q_empty      = (fill_q == '0);
	assign q_full       = (fill_q == FULL);
	assign gen_inc      = gen_rd_q + gsa_pkg::GEN_W'(1);

	always_comb begin
		do_pop   = 1'b0;
		do_push  = 1'b0;
		r_index  = idx_q[gsa_pkg::HIDX_W-1:0];
		r_gen    = '0;
		r_alive  = 1'b0;
		r_status = gsa_pkg::ST_OK;
		case (mode_q)
			gsa_pkg::MODE_CREATE: begin
				if (q_empty) begin
					r_status = gsa_pkg::ST_NONE_FREE;
					r_index  = '0;
				end else begin
					do_pop  = 1'b1;
					r_index = gsa_pkg::HIDX_W'(slot_q);
					r_gen   = gen_rd_q;
				end
			end
			gsa_pkg::MODE_DESTROY: begin
				if (!idx_ok) begin
					r_status = gsa_pkg::ST_INVALID;
				end else if (q_full) begin
					r_status = gsa_pkg::ST_OVERFLOW;
					r_gen    = gen_rd_q;
				end else begin
					do_push = 1'b1;
					r_gen   = gen_inc;
				end
			end
			gsa_pkg::MODE_CHECK: begin
				if (!idx_ok) begin
					r_status = gsa_pkg::ST_INVALID;
				end else begin
					r_gen   = gen_rd_q;
					r_alive = (gen_rd_q == gen_in_q);
				end
			end
			default: r_status = gsa_pkg::ST_OK;
		endcase
	end

	always_comb begin
		alloc_next = alloc_q;
		if (do_pop) alloc_next = alloc_q + CW'(1);
		else if (do_push && alloc_q != '0) alloc_next = alloc_q - CW'(1);
	end

	assign gen_re    = cmd.capture || cmd.slot_rd;
	assign gen_raddr = cmd.capture ? entity_index[IW-1:0] : pop_slot;
	assign gen_we    = cmd.clr || (cmd.exec && do_push);
	assign gen_waddr = cmd.clr ? clr_q : slot_q;
	assign gen_wdata = cmd.clr ? '0 : gen_inc;
	assign q_we      = cmd.exec && do_push;

	always_ff @(posedge clk) begin
		if (gen_we) gen_mem[gen_waddr] <= gen_wdata;
		if (gen_re) gen_rd_q <= gen_mem[gen_raddr];
	end

	always_ff @(posedge clk) begin
		if (q_we) queue_mem[tail_q] <= slot_q;
		if (cmd.capture) q_rd_q <= queue_mem[head_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q   <= gsa_pkg::mode_t'(mode);
			idx_q    <= entity_index;
			gen_in_q <= entity_generation;
			slot_q   <= entity_index[IW-1:0];
		end else if (cmd.slot_rd) begin
			slot_q <= pop_slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			wrap_q  <= 1'b0;
			fill_q  <= FULL;
			alloc_q <= '0;
			clr_q   <= '0;
		end else begin
			if (cmd.clr) clr_q <= (clr_q == LAST) ? '0 : clr_q + IW'(1);
			if (cmd.exec) begin
				alloc_q <= alloc_next;
				if (do_pop) begin
					head_q <= (head_q == LAST) ? '0 : head_q + IW'(1);
					fill_q <= fill_q - CW'(1);
				end
				if (do_push) begin
					tail_q <= (tail_q == LAST) ? '0 : tail_q + IW'(1);
					if (tail_q == LAST) wrap_q <= 1'b1;
					fill_q <= fill_q + CW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.exec) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			hidx_q   <= r_index;
			hgen_q   <= r_gen;
			alive_q  <= r_alive;
			status_q <= r_status;
			live_q   <= gsa_pkg::CNT_W'(alloc_next);
		end
	end

	assign stat.clr_last   = (clr_q == LAST);
	assign stat.req_create = (gsa_pkg::mode_t'(mode) == gsa_pkg::MODE_CREATE);
	assign stat.out_free   = !out_valid_q || out_ready;

	assign out_valid         = out_valid_q;
	assign handle_index      = hidx_q;
	assign handle_generation = hgen_q;
	assign is_alive          = alive_q;
	assign status            = status_q;
	assign live_count        = live_q;

endmodule

// ----- sv/generational_slot_allocator.sv -----
// Top level of the generational slot allocator.
//
//   channel   signals                                   carries
//   in        in_valid / in_ready                       mode, entity_index, entity_generation
//   out       out_valid / out_ready                     handle_index, handle_generation,
//                                                       is_alive, status, live_count
//
// Destroy, check and no-op requests go from capture straight to the update state, create
// passes a slot state in between: the generation memory read sits before the update, and
// create first reads its slot from the queue. After reset the generation table is cleared
// one entry a cycle, all SLOT_COUNT entries, with in_ready low.
// A result waiting in the output register holds the next request in its update cycle.
module generational_slot_allocator #(
	parameter int SLOT_COUNT = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   mode,
	input  logic [gsa_pkg::EIDX_W-1:0]   entity_index,
	input  logic [gsa_pkg::GEN_W-1:0]    entity_generation,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [gsa_pkg::HIDX_W-1:0]   handle_index,
	output logic [gsa_pkg::GEN_W-1:0]    handle_generation,
	output logic                         is_alive,
	output logic [1:0]                   status,
	output logic [gsa_pkg::CNT_W-1:0]    live_count
);

	gsa_pkg::cmd_t  cmd;
	gsa_pkg::stat_t stat;

	gsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	gsa_dpath #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_dpath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.stat              (stat),
		.mode              (mode),
		.entity_index      (entity_index),
		.entity_generation (entity_generation),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.handle_index      (handle_index),
		.handle_generation (handle_generation),
		.is_alive          (is_alive),
		.status            (status),
		.live_count        (live_count)
	);

endmodule

// ----- sv/gsa_checker.sv -----
// Port-level assertions of the slot allocator and their bind.
module gsa_checker #(
	parameter int SLOT_COUNT = 1024
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [gsa_pkg::HIDX_W-1:0]   handle_index,
	input logic [gsa_pkg::GEN_W-1:0]    handle_generation,
	input logic                         is_alive,
	input logic [1:0]                   status,
	input logic [gsa_pkg::CNT_W-1:0]    live_count
);

	// A stalled result keeps its index, generation, status and live count.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(handle_index)
			&& $stable(handle_generation) && $stable(status) && $stable(live_count))
		else $error("result changed while stalled");

	// Only one request is in work at a time.
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while another is in work");

	a_alive_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_alive |-> status == gsa_pkg::ST_OK)
		else $error("alive reported with an error status");

	a_none_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == gsa_pkg::ST_NONE_FREE |->
			handle_index == '0 && handle_generation == '0 && !is_alive)
		else $error("failed create returned a handle");

	a_live_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(live_count) <= SLOT_COUNT)
		else $error("live count above slot count");

endmodule

bind generational_slot_allocator gsa_checker #(.SLOT_COUNT(SLOT_COUNT)) u_gsa_chk (.*);
